// ===== design/dmwp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwp_pkg
// Shared types and constants for the DAG maximum weight path core.
// ----------------------------------------------------------------------------
package dmwp_pkg;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_WEIGHT = 2'd1;
   localparam logic [1:0] REQ_EDGE   = 2'd2;
   localparam logic [1:0] REQ_SOLVE  = 2'd3;

   localparam logic signed [63:0] NO_PATH = -64'sd9999999999999;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_EDGE_RD,
      OP_EDGE_WR,
      OP_INIT_RD,
      OP_INIT_WR,
      OP_WALK_CHK,
      OP_WALK_ROOT,
      OP_PUSH_ROOT,
      OP_TOP_RD,
      OP_TOP,
      OP_EDGE_FETCH,
      OP_VISIT,
      OP_PUSH,
      OP_REL_RD,
      OP_REL_NODE,
      OP_REL_LOAD,
      OP_REL_EDGE,
      OP_REL_FETCH,
      OP_REL_UPD,
      OP_FIN_RD,
      OP_FIN_CMP,
      OP_DONE
   } op_type;

   typedef struct packed {
      logic clr_last;
      logic edge_ok;
      logic edge_full;
      logic n_zero;
      logic i_last;
      logic visited;
      logic top_nil;
      logic push_ok;
      logic sp_last;
      logic u_ok;
      logic t_nil;
      logic j_ok;
   } stat_type;

endpackage

// ===== design/dag_max_weight_source_sink_path_core.sv =====
// ----------------------------------------------------------------------------
// dag_max_weight_source_sink_path_core
// Largest node-weighted source-to-sink path sum of a loaded DAG.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the solve result
// appears for one cycle on rsp_strobe and must be taken then. After reset a
// clearing pass runs before the first item. Clear items, kept edge items and
// solve items hold busy while they run; weight items and ignored or dropped
// edge items do not.
module dag_max_weight_source_sink_path_core
   import dmwp_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [10:0]        req_node_index,
   input  logic signed [31:0] req_node_weight,
   input  logic [10:0]        req_edge_from,
   input  logic [10:0]        req_edge_to,
   output logic               rsp_strobe,
   output logic signed [63:0] rsp_best_total,
   output logic               rsp_status,
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_wr_data
);

   op_type   op;
   stat_type stat;

   dmwp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .op       (op),
      .busy     (busy)
   );

   dmwp_dp #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_type        (req_type),
      .req_node_index  (req_node_index),
      .req_node_weight (req_node_weight),
      .req_edge_from   (req_edge_from),
      .req_edge_to     (req_edge_to),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .stat            (stat),
      .best_total      (rsp_best_total),
      .dropped         (rsp_status)
   );

   assign rsp_strobe = (op == OP_DONE);

endmodule

// ===== design/dmwp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmwp_ctrl
// Sequencer: load, clear, depth-first ordering, relaxation and sink scan.
// ----------------------------------------------------------------------------
module dmwp_ctrl
   import dmwp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_type,
   input  stat_type   stat,
   output op_type     op,
   output logic       busy
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_EDGE_RD, ST_EDGE_WR, ST_INIT_RD, ST_INIT_WR,
      ST_WALK_CHK, ST_WALK_ROOT, ST_PUSH_ROOT, ST_TOP_RD, ST_TOP,
      ST_EDGE_FETCH, ST_VISIT, ST_PUSH, ST_REL_RD, ST_REL_NODE, ST_REL_LOAD,
      ST_REL_EDGE, ST_REL_FETCH, ST_REL_UPD, ST_FIN_RD, ST_FIN_CMP, ST_DONE
   } state_type;

   state_type state_ff;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:       op = start ? OP_ACCEPT : OP_IDLE;
         ST_CLEAR:      op = OP_CLEAR;
         ST_EDGE_RD:    op = OP_EDGE_RD;
         ST_EDGE_WR:    op = OP_EDGE_WR;
         ST_INIT_RD:    op = OP_INIT_RD;
         ST_INIT_WR:    op = OP_INIT_WR;
         ST_WALK_CHK:   op = OP_WALK_CHK;
         ST_WALK_ROOT:  op = OP_WALK_ROOT;
         ST_PUSH_ROOT:  op = OP_PUSH_ROOT;
         ST_TOP_RD:     op = OP_TOP_RD;
         ST_TOP:        op = OP_TOP;
         ST_EDGE_FETCH: op = OP_EDGE_FETCH;
         ST_VISIT:      op = OP_VISIT;
         ST_PUSH:       op = OP_PUSH;
         ST_REL_RD:     op = OP_REL_RD;
         ST_REL_NODE:   op = OP_REL_NODE;
         ST_REL_LOAD:   op = OP_REL_LOAD;
         ST_REL_EDGE:   op = OP_REL_EDGE;
         ST_REL_FETCH:  op = OP_REL_FETCH;
         ST_REL_UPD:    op = OP_REL_UPD;
         ST_FIN_RD:     op = OP_FIN_RD;
         ST_FIN_CMP:    op = OP_FIN_CMP;
         ST_DONE:       op = OP_DONE;
         default:       op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  unique case (req_type)
                     REQ_CLEAR:  state_ff <= ST_CLEAR;
                     REQ_WEIGHT: state_ff <= ST_IDLE;
                     REQ_EDGE:   state_ff <= (stat.edge_ok && !stat.edge_full) ?
                                             ST_EDGE_RD : ST_IDLE;
                     default:    state_ff <= stat.n_zero ? ST_DONE : ST_INIT_RD;
                  endcase
               end
            end
            ST_CLEAR:      if (stat.clr_last) state_ff <= ST_IDLE;
            ST_EDGE_RD:    state_ff <= ST_EDGE_WR;
            ST_EDGE_WR:    state_ff <= ST_IDLE;
            ST_INIT_RD:    state_ff <= ST_INIT_WR;
            ST_INIT_WR:    state_ff <= stat.i_last ? ST_WALK_CHK : ST_INIT_RD;
            ST_WALK_CHK:   state_ff <= ST_WALK_ROOT;
            ST_WALK_ROOT: begin
               if (!stat.visited) state_ff <= ST_PUSH_ROOT;
               else state_ff <= stat.i_last ? ST_REL_RD : ST_WALK_CHK;
            end
            ST_PUSH_ROOT:  state_ff <= ST_TOP_RD;
            ST_TOP_RD:     state_ff <= ST_TOP;
            ST_TOP: begin
               if (!stat.top_nil) state_ff <= ST_EDGE_FETCH;
               else if (!stat.sp_last) state_ff <= ST_TOP_RD;
               else state_ff <= stat.i_last ? ST_REL_RD : ST_WALK_CHK;
            end
            ST_EDGE_FETCH: state_ff <= ST_VISIT;
            ST_VISIT:      state_ff <= stat.push_ok ? ST_PUSH : ST_TOP_RD;
            ST_PUSH:       state_ff <= ST_TOP_RD;
            ST_REL_RD:     state_ff <= ST_REL_NODE;
            ST_REL_NODE: begin
               if (stat.u_ok) state_ff <= ST_REL_LOAD;
               else state_ff <= stat.i_last ? ST_FIN_RD : ST_REL_RD;
            end
            ST_REL_LOAD:   state_ff <= ST_REL_EDGE;
            ST_REL_EDGE: begin
               if (!stat.t_nil) state_ff <= ST_REL_FETCH;
               else state_ff <= stat.i_last ? ST_FIN_RD : ST_REL_RD;
            end
            ST_REL_FETCH:  state_ff <= stat.j_ok ? ST_REL_UPD : ST_REL_EDGE;
            ST_REL_UPD:    state_ff <= ST_REL_EDGE;
            ST_FIN_RD:     state_ff <= ST_FIN_CMP;
            ST_FIN_CMP:    state_ff <= stat.i_last ? ST_DONE : ST_FIN_RD;
            ST_DONE:       state_ff <= ST_IDLE;
            default:       state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== design/dmwp_dp.sv =====
// ----------------------------------------------------------------------------
// dmwp_dp
// Graph stores, walk stack, counters and the 64-bit relaxation datapath.
// ----------------------------------------------------------------------------
module dmwp_dp
   import dmwp_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
)
(
   input  logic               clock,
   input  logic               reset,
   input  op_type             op,
   input  logic [1:0]         req_type,
   input  logic [10:0]        req_node_index,
   input  logic signed [31:0] req_node_weight,
   input  logic [10:0]        req_edge_from,
   input  logic [10:0]        req_edge_to,
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_wr_data,
   output stat_type           stat,
   output logic signed [63:0] best_total,
   output logic               dropped
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

   logic signed [31:0] w_mem [MAX_NODES];
   logic signed [63:0] b_mem [MAX_NODES];
   logic [EW-1:0]      lh_mem [MAX_NODES];
   logic               in_mem [MAX_NODES];
   logic               out_mem [MAX_NODES];
   logic               vis_mem [MAX_NODES];
   logic [NW-1:0]      topo_mem [MAX_NODES];
   logic [NW-1:0]      sn_mem [MAX_NODES];
   logic [EW-1:0]      sx_mem [MAX_NODES];
   logic [NW-1:0]      et_mem [MAX_EDGES];
   logic [EW-1:0]      el_mem [MAX_EDGES];

   logic signed [31:0] w_q;
   logic signed [63:0] b_q;
   logic [EW-1:0]      lh_q, sx_q, el_q;
   logic               in_q, out_q, vis_q;
   logic [NW-1:0]      topo_q, sn_q, et_q;

   logic               w_we, b_we, lh_we, in_we, out_we, vis_we, topo_we, s_we, e_we;
   logic [NW-1:0]      w_wa, b_wa, lh_wa, in_wa, out_wa, vis_wa, topo_wa, s_wa;
   logic [NW-1:0]      w_ra, b_ra, lh_ra, in_ra, out_ra, vis_ra, topo_ra, s_ra;
   logic [EA-1:0]      e_wa, e_ra;
   logic signed [31:0] w_wd;
   logic signed [63:0] b_wd;
   logic [EW-1:0]      lh_wd, sx_wd, el_wd;
   logic               in_wd, out_wd, vis_wd;
   logic [NW-1:0]      topo_wd, sn_wd, et_wd;

   logic [10:0]        num_ff;
   logic [CW-1:0]      n_ff, i_ff, sp_ff, slot_ff;
   logic [EW-1:0]      ec_ff, t_ff;
   logic               drop_ff;
   logic [NW-1:0]      from_ff, to_ff, u_ff, j_ff, top_node_ff;
   logic signed [63:0] bu_ff, ans_ff;

   logic [CW-1:0]      n_eff, i_next;
   logic [NW-1:0]      i_a, sp_m1, slot_m1;
   logic               idx_ok;
   logic signed [63:0] cand;

   assign best_total = ans_ff;
   assign dropped    = drop_ff;

   assign n_eff   = (32'(num_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(num_ff);
   assign i_a     = i_ff[NW-1:0];
   assign sp_m1   = NW'(sp_ff - CW'(1));
   assign slot_m1 = NW'(slot_ff - CW'(1));
   assign i_next  = stat.i_last ? '0 : i_ff + CW'(1);
   assign idx_ok  = (req_node_index != 11'd0) && (32'(req_node_index) <= MAX_NODES);
   assign cand    = bu_ff + {{32{w_q[31]}}, w_q};

   always_comb begin
      stat.clr_last  = (i_ff == CW'(MAX_NODES - 1));
      stat.edge_ok   = (req_edge_from != 11'd0) && (req_edge_to != 11'd0) &&
                       (32'(req_edge_from) <= MAX_NODES) && (32'(req_edge_to) <= MAX_NODES);
      stat.edge_full = (ec_ff == NIL);
      stat.n_zero    = (n_eff == '0);
      stat.i_last    = (i_ff == n_ff - CW'(1));
      stat.visited   = vis_q;
      stat.top_nil   = (sx_q == NIL);
      stat.push_ok   = (CW'(j_ff) < n_ff) && !vis_q && (sp_ff < CW'(MAX_NODES));
      stat.sp_last   = (sp_ff == CW'(1));
      stat.u_ok      = (CW'(topo_q) < n_ff);
      stat.t_nil     = (t_ff == NIL);
      stat.j_ok      = (CW'(et_q) < n_ff);
   end

   always_comb begin
      w_we = 1'b0; b_we = 1'b0; lh_we = 1'b0; in_we = 1'b0; out_we = 1'b0;
      vis_we = 1'b0; topo_we = 1'b0; s_we = 1'b0; e_we = 1'b0;
      w_wa = '0; b_wa = '0; lh_wa = '0; in_wa = '0; out_wa = '0;
      vis_wa = '0; topo_wa = '0; s_wa = '0; e_wa = '0;
      w_ra = '0; b_ra = '0; lh_ra = '0; in_ra = '0; out_ra = '0;
      vis_ra = '0; topo_ra = '0; s_ra = '0; e_ra = '0;
      w_wd = req_node_weight; b_wd = cand; lh_wd = NIL; in_wd = 1'b0; out_wd = 1'b0;
      vis_wd = 1'b0; topo_wd = sn_q; sn_wd = i_a; sx_wd = lh_q;
      et_wd = to_ff; el_wd = lh_q;
      unique case (op)
         OP_ACCEPT: begin
            if (req_type == REQ_WEIGHT && idx_ok) begin
               w_we = 1'b1;
               w_wa = NW'(req_node_index - 11'd1);
            end
         end
         OP_CLEAR: begin
            lh_we = 1'b1; lh_wa = i_a;
            in_we = 1'b1; in_wa = i_a;
            out_we = 1'b1; out_wa = i_a;
         end
         OP_EDGE_RD: lh_ra = from_ff;
         OP_EDGE_WR: begin
            e_we = 1'b1; e_wa = ec_ff[EA-1:0];
            lh_we = 1'b1; lh_wa = from_ff; lh_wd = ec_ff;
            out_we = 1'b1; out_wa = from_ff; out_wd = 1'b1;
            in_we = 1'b1; in_wa = to_ff; in_wd = 1'b1;
         end
         OP_INIT_RD: begin
            in_ra = i_a; w_ra = i_a;
         end
         OP_INIT_WR: begin
            b_we = 1'b1; b_wa = i_a;
            b_wd = in_q ? NO_PATH : {{32{w_q[31]}}, w_q};
            vis_we = 1'b1; vis_wa = i_a;
         end
         OP_WALK_CHK: vis_ra = i_a;
         OP_WALK_ROOT: begin
            vis_we = !vis_q; vis_wa = i_a; vis_wd = 1'b1;
            lh_ra = i_a;
         end
         OP_PUSH_ROOT: s_we = 1'b1;
         OP_TOP_RD: s_ra = sp_m1;
         OP_TOP: begin
            topo_we = stat.top_nil && (slot_ff != '0);
            topo_wa = slot_m1;
            e_ra = sx_q[EA-1:0];
         end
         OP_EDGE_FETCH: begin
            s_we = 1'b1; s_wa = sp_m1; sn_wd = top_node_ff; sx_wd = el_q;
            vis_ra = et_q;
         end
         OP_VISIT: begin
            vis_we = stat.push_ok; vis_wa = j_ff; vis_wd = 1'b1;
            lh_ra = j_ff;
         end
         OP_PUSH: begin
            s_we = 1'b1; s_wa = sp_ff[NW-1:0]; sn_wd = j_ff;
         end
         OP_REL_RD: topo_ra = i_a;
         OP_REL_NODE: begin
            lh_ra = topo_q; b_ra = topo_q;
         end
         OP_REL_EDGE: e_ra = t_ff[EA-1:0];
         OP_REL_FETCH: begin
            b_ra = et_q; w_ra = et_q;
         end
         OP_REL_UPD: begin
            b_we = (cand > b_q); b_wa = j_ff;
         end
         OP_FIN_RD: begin
            out_ra = i_a; b_ra = i_a;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_wa] <= w_wd;
      w_q <= w_mem[w_ra];
      if (b_we) b_mem[b_wa] <= b_wd;
      b_q <= b_mem[b_ra];
      if (lh_we) lh_mem[lh_wa] <= lh_wd;
      lh_q <= lh_mem[lh_ra];
      if (in_we) in_mem[in_wa] <= in_wd;
      in_q <= in_mem[in_ra];
      if (out_we) out_mem[out_wa] <= out_wd;
      out_q <= out_mem[out_ra];
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_q <= vis_mem[vis_ra];
      if (topo_we) topo_mem[topo_wa] <= topo_wd;
      topo_q <= topo_mem[topo_ra];
      if (s_we) begin
         sn_mem[s_wa] <= sn_wd;
         sx_mem[s_wa] <= sx_wd;
      end
      sn_q <= sn_mem[s_ra];
      sx_q <= sx_mem[s_ra];
      if (e_we) begin
         et_mem[e_wa] <= et_wd;
         el_mem[e_wa] <= el_wd;
      end
      et_q <= et_mem[e_ra];
      el_q <= el_mem[e_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= 11'd1;
         ec_ff   <= '0;
         drop_ff <= 1'b0;
         i_ff    <= '0;
         sp_ff   <= '0;
         slot_ff <= '0;
         n_ff    <= '0;
      end else begin
         if (csr_wr_en) num_ff <= csr_wr_data;
         case (op)
            OP_ACCEPT: begin
               from_ff <= NW'(req_edge_from - 11'd1);
               to_ff   <= NW'(req_edge_to - 11'd1);
               case (req_type)
                  REQ_CLEAR: i_ff <= '0;
                  REQ_EDGE:  if (stat.edge_ok && stat.edge_full) drop_ff <= 1'b1;
                  REQ_SOLVE: begin
                     n_ff    <= n_eff;
                     slot_ff <= n_eff;
                     i_ff    <= '0;
                     ans_ff  <= NO_PATH;
                  end
                  default: ;
               endcase
            end
            OP_CLEAR: begin
               i_ff    <= i_ff + CW'(1);
               ec_ff   <= '0;
               drop_ff <= 1'b0;
            end
            OP_EDGE_WR:   ec_ff <= ec_ff + EW'(1);
            OP_INIT_WR:   i_ff <= i_next;
            OP_WALK_ROOT: if (vis_q) i_ff <= i_next;
            OP_PUSH_ROOT: sp_ff <= CW'(1);
            OP_TOP: begin
               top_node_ff <= sn_q;
               if (stat.top_nil) begin
                  if (slot_ff != '0) slot_ff <= slot_ff - CW'(1);
                  sp_ff <= sp_ff - CW'(1);
                  if (stat.sp_last) i_ff <= i_next;
               end
            end
            OP_EDGE_FETCH: j_ff <= et_q;
            OP_PUSH:       sp_ff <= sp_ff + CW'(1);
            OP_REL_NODE: begin
               u_ff <= topo_q;
               if (!stat.u_ok) i_ff <= i_next;
            end
            OP_REL_LOAD: begin
               t_ff  <= lh_q;
               bu_ff <= b_q;
            end
            OP_REL_EDGE: if (stat.t_nil) i_ff <= i_next;
            OP_REL_FETCH: begin
               j_ff <= et_q;
               t_ff <= el_q;
            end
            OP_REL_UPD: if (cand > b_q && j_ff == u_ff) bu_ff <= cand;
            OP_FIN_CMP: begin
               if (!out_q && b_q > ans_ff) ans_ff <= b_q;
               i_ff <= i_next;
            end
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(MAX_NODES)) else $error("walk stack pointer out of range");
   a_ec_bound: assert property (@(posedge clock) disable iff (reset)
      ec_ff <= NIL) else $error("edge count out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      op == OP_PUSH |-> sp_ff < CW'(MAX_NODES)) else $error("push on full stack");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      op == OP_TOP |-> slot_ff <= n_ff) else $error("order slot out of range");
`endif

endmodule

// ===== test/tb_dag_max_weight_source_sink_path_core.sv =====
// ----------------------------------------------------------------------------
// tb_dag_max_weight_source_sink_path_core
// Self-checking bench for the DAG maximum weight path core.
// ----------------------------------------------------------------------------
// The graph is built item by item, then solved. A scoreboard mirrors the
// graph state and works out each solve's best sum and dropped status.
// Directed graphs cover the corners (no sinks, empty range, full edge store,
// ignored node numbers, out-of-range targets). Random graphs follow, under
// changing sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dag_max_weight_source_sink_path_core;
   import dmwp_pkg::*;

   localparam int NODE_CAP = 1024;
   localparam int EDGE_CAP = 4096;
   localparam int LIMIT    = 4000000;

   class path_scoreboard;
      int               nodes_in_use;
      logic signed [31:0] wt[NODE_CAP];
      bit               wt_seen[NODE_CAP];
      int               head[NODE_CAP];
      int               indeg[NODE_CAP];
      int               outdeg[NODE_CAP];
      int               tgt[EDGE_CAP];
      int               lnk[EDGE_CAP];
      int               ecnt;
      bit               dropped;
      logic signed [63:0] exp_total[$];
      bit               exp_status[$];
      int               errors;

      function new();
         nodes_in_use = 1;
         errors = 0;
         foreach (wt_seen[i]) wt_seen[i] = 0;
         clear_graph();
      endfunction

      function void clear_graph();
         for (int i = 0; i < NODE_CAP; i++) begin
            head[i] = EDGE_CAP;
            indeg[i] = 0;
            outdeg[i] = 0;
         end
         ecnt = 0;
         dropped = 0;
      endfunction

      function logic signed [63:0] best_path_sum();
         int n, slot, sp, t, j, u;
         bit vis[NODE_CAP];
         logic signed [63:0] best[NODE_CAP];
         int order[NODE_CAP];
         int snode[NODE_CAP];
         int snext[NODE_CAP];
         logic signed [63:0] ans, cand;
         n = nodes_in_use > NODE_CAP ? NODE_CAP : nodes_in_use;
         for (int i = 0; i < n; i++) begin
            best[i] = indeg[i] == 0 ? 64'(wt[i]) : NO_PATH;
            vis[i] = 0;
         end
         slot = n;
         for (int i = 0; i < n; i++) begin
            if (!vis[i]) begin
               vis[i] = 1;
               sp = 1;
               snode[0] = i;
               snext[0] = head[i];
               while (sp > 0) begin
                  if (snext[sp-1] < EDGE_CAP) begin
                     t = snext[sp-1];
                     j = tgt[t];
                     snext[sp-1] = lnk[t];
                     if (j < n && !vis[j] && sp < NODE_CAP) begin
                        vis[j] = 1;
                        snode[sp] = j;
                        snext[sp] = head[j];
                        sp++;
                     end
                  end else begin
                     if (slot > 0) begin
                        slot--;
                        order[slot] = snode[sp-1];
                     end
                     sp--;
                  end
               end
            end
         end
         for (int k = 0; k < n; k++) begin
            u = order[k];
            if (u < n) begin
               t = head[u];
               while (t < EDGE_CAP) begin
                  j = tgt[t];
                  if (j < n) begin
                     cand = best[u] + 64'(wt[j]);
                     if (cand > best[j]) best[j] = cand;
                  end
                  t = lnk[t];
               end
            end
         end
         ans = NO_PATH;
         for (int i = 0; i < n; i++)
            if (outdeg[i] == 0 && ans < best[i]) ans = best[i];
         return ans;
      endfunction

      function void note_item(logic [1:0] kind, logic [10:0] idx, logic signed [31:0] w,
                              logic [10:0] src, logic [10:0] dst);
         case (kind)
            REQ_CLEAR: clear_graph();
            REQ_WEIGHT: begin
               if (idx >= 1 && idx <= NODE_CAP) begin
                  wt[idx-1] = w;
                  wt_seen[idx-1] = 1;
               end
            end
            REQ_EDGE: begin
               if (src >= 1 && src <= NODE_CAP && dst >= 1 && dst <= NODE_CAP) begin
                  if (ecnt >= EDGE_CAP) dropped = 1;
                  else begin
                     tgt[ecnt] = dst - 1;
                     lnk[ecnt] = head[src-1];
                     head[src-1] = ecnt;
                     ecnt++;
                     outdeg[src-1]++;
                     indeg[dst-1]++;
                  end
               end
            end
            default: begin
               exp_total.push_back(best_path_sum());
               exp_status.push_back(dropped);
            end
         endcase
      endfunction

      function void check_result(logic signed [63:0] total, logic status);
         logic signed [63:0] et;
         bit es;
         if (exp_total.size() == 0) begin
            $display("%0t unexpected result: expected none, got total %0d status %0d",
                     $time, total, status);
            errors++;
            return;
         end
         et = exp_total.pop_front();
         es = exp_status.pop_front();
         if (total !== et) begin
            $display("%0t best_total: expected %0d, got %0d", $time, et, total);
            errors++;
         end
         if (status !== es) begin
            $display("%0t status: expected %0d, got %0d", $time, es, status);
            errors++;
         end
      endfunction

      function int pending();
         return exp_total.size();
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_type = REQ_CLEAR;
   logic [10:0]        req_node_index = '0;
   logic signed [31:0] req_node_weight = '0;
   logic [10:0]        req_edge_from = '0;
   logic [10:0]        req_edge_to = '0;
   logic               rsp_strobe;
   logic signed [63:0] rsp_best_total;
   logic               rsp_status;
   logic               csr_wr_en = 0;
   logic [10:0]        csr_wr_data = '0;

   path_scoreboard sb = new();
   int idle_pct = 0;
   int rand_items = 0;
   int cycles = 0;

   dag_max_weight_source_sink_path_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_node_index (req_node_index),
      .req_node_weight(req_node_weight),
      .req_edge_from  (req_edge_from),
      .req_edge_to    (req_edge_to),
      .rsp_strobe     (rsp_strobe),
      .rsp_best_total (rsp_best_total),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_strobe) sb.check_result(rsp_best_total, rsp_status);

   task automatic send_item(logic [1:0] kind, logic [10:0] idx, logic signed [31:0] w,
                            logic [10:0] src, logic [10:0] dst);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_node_index  <= idx;
      req_node_weight <= w;
      req_edge_from   <= src;
      req_edge_to     <= dst;
      do @(posedge clock); while (busy);
      sb.note_item(kind, idx, w, src, dst);
      rand_items++;
   endtask

   task automatic put_weight(logic [10:0] idx, logic signed [31:0] w);
      send_item(REQ_WEIGHT, idx, w, 11'($urandom), 11'($urandom));
   endtask

   task automatic put_edge(logic [10:0] src, logic [10:0] dst);
      send_item(REQ_EDGE, 11'($urandom), $urandom, src, dst);
   endtask

   task automatic put_clear();
      send_item(REQ_CLEAR, 11'($urandom), $urandom, 11'($urandom), 11'($urandom));
   endtask

   task automatic put_solve();
      int n;
      n = sb.nodes_in_use > NODE_CAP ? NODE_CAP : sb.nodes_in_use;
      for (int i = 1; i <= n; i++)
         if (!sb.wt_seen[i-1]) put_weight(11'(i), $urandom);
      send_item(REQ_SOLVE, 11'($urandom), $urandom, 11'($urandom), 11'($urandom));
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_nodes(int v);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 11'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.nodes_in_use = v;
   endtask

   function automatic logic signed [31:0] pick_weight();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_graph();
      int nn, ne;
      logic [10:0] a, b;
      nn = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
      set_nodes(nn);
      if ($urandom_range(4) != 0) put_clear();
      for (int i = 1; i <= nn; i++)
         if ($urandom_range(3) != 0 || !sb.wt_seen[i-1]) put_weight(11'(i), pick_weight());
      ne = $urandom_range(0, 2 * nn);
      for (int e = 0; e < ne; e++) begin
         case ($urandom_range(19))
            0, 1, 2: begin
               a = 11'($urandom_range(1, nn + 2));
               b = 11'($urandom_range(1, nn + 2));
            end
            3: begin
               a = 11'($urandom);
               b = 11'($urandom);
            end
            4: begin
               put_weight(11'($urandom), $urandom);
               continue;
            end
            default: begin
               a = 11'($urandom_range(1, nn));
               b = 11'($urandom_range(1, nn));
               if (a > b) {a, b} = {b, a};
               if (a == b) b = b + 1;
            end
         endcase
         put_edge(a, b);
      end
      put_solve();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy);

      // single node, ignored weight indexes
      put_weight(11'd1, 32'sh7fffffff);
      put_weight(11'd0, 32'sh12345678);
      put_weight(11'd1025, -32'sd5);
      put_weight(11'd2047, 32'sh80000000);
      put_edge(11'd0, 11'd1);
      put_edge(11'd1, 11'd2047);
      put_solve();
      // chain with shortcut, target past range, self-loop
      set_nodes(3);
      put_weight(11'd2, 32'sh80000000);
      put_weight(11'd3, -32'sd1);
      put_edge(11'd1, 11'd2);
      put_edge(11'd2, 11'd3);
      put_edge(11'd1, 11'd3);
      put_edge(11'd3, 11'd6);
      put_solve();
      put_clear();
      put_edge(11'd2, 11'd2);
      put_edge(11'd3, 11'd1);
      put_edge(11'd1, 11'd3);
      put_solve();
      set_nodes(0);
      put_solve();
      // every node in use, beyond the cap
      set_nodes(2047);
      put_clear();
      put_edge(11'd1024, 11'd1);
      put_edge(11'd1, 11'd512);
      put_solve();
      // full edge store
      set_nodes(4);
      put_clear();
      idle_pct = 87;
      for (int e = 0; e < EDGE_CAP + 3; e++)
         put_edge(11'($urandom_range(1, 4)), 11'($urandom_range(1, 5)));
      put_solve();
      put_clear();
      put_solve();
      set_nodes(1024);
      put_solve();

      rand_items = 0;
      for (int ph = 0; rand_items < 500; ph++) begin
         case (ph % 3)
            0: idle_pct = 0;
            1: idle_pct = 87;
            default: idle_pct = 12;
         endcase
         random_graph();
         if (ph % 5 == 4) wait_quiet();
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dmwp_pkg.sv
design/dmwp_ctrl.sv
design/dmwp_dp.sv
design/dag_max_weight_source_sink_path_core.sv
test/tb_dag_max_weight_source_sink_path_core.sv
